// ===== hdl/pnf_pkg.sv =====
// Package for the place/transition net firing engine.
// Holds operation codes, sequencer states and the words passed between cells.
// No dependencies.
package pnf_pkg;

    localparam int VALUE_W   = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PLACES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TRANS  = 2'd1;
    localparam logic [CNT_W-1:0]     CNT_RESET      = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_SET_IN   = 3'd0,
        OP_SET_OUT  = 3'd1,
        OP_SET_MARK = 3'd2,
        OP_FIRE     = 3'd3,
        OP_TEST     = 3'd4,
        OP_RD_MARK  = 3'd5,
        OP_RD_IN    = 3'd6,
        OP_RD_OUT   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        RSEL_TOK = 2'd0,
        RSEL_IN  = 2'd1,
        RSEL_OUT = 2'd2
    } t_rsel;

    typedef enum logic [2:0] {
        ST_CLEAR      = 3'd0,
        ST_IDLE       = 3'd1,
        ST_ISSUE      = 3'd2,
        ST_LAUNCH_CHK = 3'd3,
        ST_WAIT_CHK   = 3'd4,
        ST_LAUNCH_UPD = 3'd5,
        ST_WAIT_UPD   = 3'd6,
        ST_DONE       = 3'd7
    } t_state;

    typedef struct packed {
        logic  clear;
        logic  wr_in;
        logic  wr_out;
        logic  wr_tok;
        t_rsel rd_sel;
    } t_cell_ctl;

    typedef struct packed {
        logic               act;
        logic               upd;
        logic               en;
        logic               sat;
        logic [VALUE_W-1:0] val;
    } t_word;

endpackage

// ===== hdl/pnf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pnf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pnf_cell.sv =====
// One place of the net: its token count and its input and output arc weights for every transition.
// Depends on pnf_pkg and pnf_ram.
module pnf_cell #(
    parameter int WEIGHT_BITS     = 16,
    parameter int MAX_TRANSITIONS = 16,
    parameter int CELL_IDX        = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pnf_pkg::t_cell_ctl                 i_ctl,
    input  logic [pnf_pkg::CNT_W-1:0]          i_num_places,
    input  logic [pnf_pkg::IDX_W-1:0]          i_place,
    input  logic [$clog2(MAX_TRANSITIONS)-1:0] i_waddr,
    input  logic [$clog2(MAX_TRANSITIONS)-1:0] i_raddr,
    input  logic [WEIGHT_BITS-1:0]             i_wdata,
    input  pnf_pkg::t_word                     i_word,
    output pnf_pkg::t_word                     o_word
);

    localparam int VW = pnf_pkg::VALUE_W;

    logic [WEIGHT_BITS-1:0]    r_tok;
    logic [WEIGHT_BITS-1:0]    n_tok;
    pnf_pkg::t_word            r_word;
    pnf_pkg::t_word            n_word;
    logic [WEIGHT_BITS-1:0]    w_in_rd;
    logic [WEIGHT_BITS-1:0]    w_out_rd;
    logic [WEIGHT_BITS-1:0]    w_ram_wdata;
    logic                      w_we_in;
    logic                      w_we_out;
    logic                      w_sel;
    logic                      w_active;
    logic [WEIGHT_BITS:0]      w_sum;
    logic [WEIGHT_BITS+VW-1:0] w_tok_ext;
    logic [WEIGHT_BITS+VW-1:0] w_in_ext;
    logic [WEIGHT_BITS+VW-1:0] w_out_ext;

    assign w_sel       = int'(i_place) == CELL_IDX;
    assign w_active    = int'(i_num_places) > CELL_IDX;
    assign w_we_in     = i_ctl.clear | (i_ctl.wr_in & w_sel);
    assign w_we_out    = i_ctl.clear | (i_ctl.wr_out & w_sel);
    assign w_ram_wdata = i_ctl.clear ? '0 : i_wdata;

    pnf_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_TRANSITIONS)
    ) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_in),
        .i_waddr (i_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (i_raddr),
        .o_rdata (w_in_rd)
    );

    pnf_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_TRANSITIONS)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_out),
        .i_waddr (i_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (i_raddr),
        .o_rdata (w_out_rd)
    );

    assign w_sum     = {1'b0, r_tok} - {1'b0, w_in_rd} + {1'b0, w_out_rd};
    assign w_tok_ext = {{VW{1'b0}}, r_tok};
    assign w_in_ext  = {{VW{1'b0}}, w_in_rd};
    assign w_out_ext = {{VW{1'b0}}, w_out_rd};

    always_comb begin
        n_tok = r_tok;
        priority if (i_ctl.wr_tok && w_sel) begin
            n_tok = i_wdata;
        end else if (i_word.act && i_word.upd && w_active) begin
            n_tok = w_sum[WEIGHT_BITS] ? '1 : w_sum[WEIGHT_BITS-1:0];
        end else begin
            n_tok = r_tok;
        end
    end

    always_comb begin
        n_word = i_word;
        if (i_word.act) begin
            if (i_word.upd) begin
                if (w_active) begin
                    n_word.sat = i_word.sat | w_sum[WEIGHT_BITS];
                end
            end else begin
                if (w_active && (r_tok < w_in_rd)) begin
                    n_word.en = 1'b0;
                end
                if (w_sel) begin
                    unique case (i_ctl.rd_sel)
                        pnf_pkg::RSEL_IN:  n_word.val = w_in_ext[VW-1:0];
                        pnf_pkg::RSEL_OUT: n_word.val = w_out_ext[VW-1:0];
                        default:           n_word.val = w_tok_ext[VW-1:0];
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_word <= '0;
        end else begin
            r_tok  <= n_tok;
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== hdl/petri_net_firing_engine.sv =====
// Place/transition net firing engine: sequencer, configuration registers and a row of place cells.
// Depends on pnf_pkg and pnf_cell.
//
// Each place is a cell holding its token count and two RAMs of arc weights indexed by
// transition; a status word walks the row one cell per clock. After reset the engine runs
// a clearing pass over every RAM address, zeroing every arc weight, before it takes its
// first operation; configuration writes are taken at any time. Arc and marking writes need
// no walk of the row. Read and test operations take one walk of the row. Fire takes an
// enable check walk, then a token update walk only if the transition index is valid and
// the transition is enabled. A new operation is taken while the previous result still
// waits in the output register.
module petri_net_firing_engine #(
    parameter int MAX_PLACES      = 16,
    parameter int MAX_TRANSITIONS = 16,
    parameter int WEIGHT_BITS     = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pnf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pnf_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [pnf_pkg::OP_W-1:0]         i_op,
    input  logic [pnf_pkg::IDX_W-1:0]        i_trans_index,
    input  logic [pnf_pkg::IDX_W-1:0]        i_place_index,
    input  logic [pnf_pkg::VALUE_W-1:0]      i_weight_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_ok,
    output logic                             o_enabled,
    output logic [pnf_pkg::VALUE_W-1:0]      o_value,
    output logic                             o_saturated
);

    localparam int TW = $clog2(MAX_TRANSITIONS);
    localparam int VW = pnf_pkg::VALUE_W;
    localparam int IW = pnf_pkg::IDX_W;

    pnf_pkg::t_state             r_state;
    pnf_pkg::t_state             n_state;
    logic [pnf_pkg::CNT_W-1:0]   r_num_places;
    logic [pnf_pkg::CNT_W-1:0]   r_num_trans;
    logic [TW-1:0]               r_clr;
    pnf_pkg::t_op                r_op;
    logic [IW-1:0]               r_t;
    logic [IW-1:0]               r_p;
    logic [VW-1:0]               r_w;
    logic                        r_en;
    logic                        r_sat;
    logic [VW-1:0]               r_val;
    logic                        r_o_valid;
    logic                        r_o_ok;
    logic                        r_o_en;
    logic [VW-1:0]               r_o_val;
    logic                        r_o_sat;

    pnf_pkg::t_cell_ctl          w_ctl;
    pnf_pkg::t_word              w_head;
    pnf_pkg::t_word              w_chain [MAX_PLACES+1];
    pnf_pkg::t_word              w_end;
    logic [TW+IW-1:0]            w_t_ext;
    logic [TW-1:0]               w_t_addr;
    logic [TW-1:0]               w_waddr;
    logic [WEIGHT_BITS+VW-1:0]   w_w_ext;
    logic [WEIGHT_BITS-1:0]      w_wdata;
    logic                        w_tv;
    logic                        w_pv;
    logic                        w_accept;
    logic                        w_load_out;
    logic                        w_res_ok;
    logic                        w_res_en;
    logic [VW-1:0]               w_res_val;
    logic                        w_res_sat;

    assign w_t_ext  = {{TW{1'b0}}, r_t};
    assign w_t_addr = w_t_ext[TW-1:0];
    assign w_waddr  = (r_state == pnf_pkg::ST_CLEAR) ? r_clr : w_t_addr;
    assign w_w_ext  = {{WEIGHT_BITS{1'b0}}, r_w};
    assign w_wdata  = w_w_ext[WEIGHT_BITS-1:0];
    assign w_tv     = (int'(r_t) < int'(r_num_trans)) && (int'(r_t) < MAX_TRANSITIONS);
    assign w_pv     = (int'(r_p) < int'(r_num_places)) && (int'(r_p) < MAX_PLACES);
    assign w_chain[0] = w_head;
    assign w_end    = w_chain[MAX_PLACES];
    assign w_accept = i_in_valid & o_in_ready;

    assign o_cfg_ready = 1'b1;

    generate
        for (genvar k = 0; k < MAX_PLACES; k++) begin : g_cell
            pnf_cell #(
                .WEIGHT_BITS     (WEIGHT_BITS),
                .MAX_TRANSITIONS (MAX_TRANSITIONS),
                .CELL_IDX        (k)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_num_places (r_num_places),
                .i_place      (r_p),
                .i_waddr      (w_waddr),
                .i_raddr      (w_t_addr),
                .i_wdata      (w_wdata),
                .i_word       (w_chain[k]),
                .o_word       (w_chain[k+1])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pnf_pkg::ST_CLEAR: begin
                if (r_clr == TW'(MAX_TRANSITIONS - 1)) begin
                    n_state = pnf_pkg::ST_IDLE;
                end
            end
            pnf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = pnf_pkg::ST_ISSUE;
                end
            end
            pnf_pkg::ST_ISSUE: begin
                if (r_op == pnf_pkg::OP_SET_IN || r_op == pnf_pkg::OP_SET_OUT ||
                    r_op == pnf_pkg::OP_SET_MARK) begin
                    n_state = pnf_pkg::ST_DONE;
                end else begin
                    n_state = pnf_pkg::ST_LAUNCH_CHK;
                end
            end
            pnf_pkg::ST_LAUNCH_CHK: n_state = pnf_pkg::ST_WAIT_CHK;
            pnf_pkg::ST_WAIT_CHK: begin
                if (w_end.act) begin
                    if (r_op == pnf_pkg::OP_FIRE && w_tv && w_end.en) begin
                        n_state = pnf_pkg::ST_LAUNCH_UPD;
                    end else begin
                        n_state = pnf_pkg::ST_DONE;
                    end
                end
            end
            pnf_pkg::ST_LAUNCH_UPD: n_state = pnf_pkg::ST_WAIT_UPD;
            pnf_pkg::ST_WAIT_UPD: begin
                if (w_end.act) begin
                    n_state = pnf_pkg::ST_DONE;
                end
            end
            pnf_pkg::ST_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_state = pnf_pkg::ST_IDLE;
                end
            end
            default: n_state = pnf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == pnf_pkg::ST_IDLE);
        w_load_out    = (r_state == pnf_pkg::ST_DONE) && (!r_o_valid || i_out_ready);
        w_ctl.clear   = (r_state == pnf_pkg::ST_CLEAR);
        w_ctl.wr_in   = (r_state == pnf_pkg::ST_ISSUE) && (r_op == pnf_pkg::OP_SET_IN) &&
                        w_tv && w_pv;
        w_ctl.wr_out  = (r_state == pnf_pkg::ST_ISSUE) && (r_op == pnf_pkg::OP_SET_OUT) &&
                        w_tv && w_pv;
        w_ctl.wr_tok  = (r_state == pnf_pkg::ST_ISSUE) && (r_op == pnf_pkg::OP_SET_MARK) &&
                        w_pv;
        unique case (r_op)
            pnf_pkg::OP_RD_IN:  w_ctl.rd_sel = pnf_pkg::RSEL_IN;
            pnf_pkg::OP_RD_OUT: w_ctl.rd_sel = pnf_pkg::RSEL_OUT;
            default:            w_ctl.rd_sel = pnf_pkg::RSEL_TOK;
        endcase
        w_head.act = (r_state == pnf_pkg::ST_LAUNCH_CHK) ||
                     (r_state == pnf_pkg::ST_LAUNCH_UPD);
        w_head.upd = (r_state == pnf_pkg::ST_LAUNCH_UPD);
        w_head.en  = 1'b1;
        w_head.sat = 1'b0;
        w_head.val = '0;
    end

    always_comb begin
        w_res_ok  = 1'b0;
        w_res_en  = 1'b0;
        w_res_val = '0;
        w_res_sat = 1'b0;
        unique case (r_op)
            pnf_pkg::OP_SET_IN,
            pnf_pkg::OP_SET_OUT: w_res_ok = w_tv & w_pv;
            pnf_pkg::OP_SET_MARK: w_res_ok = w_pv;
            pnf_pkg::OP_FIRE: begin
                w_res_ok  = w_tv & r_en;
                w_res_en  = w_tv & r_en;
                w_res_sat = w_tv & r_en & r_sat;
            end
            pnf_pkg::OP_TEST: begin
                w_res_ok = w_tv;
                w_res_en = w_tv & r_en;
            end
            pnf_pkg::OP_RD_MARK: begin
                w_res_ok  = w_pv;
                w_res_val = w_pv ? r_val : '0;
            end
            default: begin
                w_res_ok  = w_tv & w_pv;
                w_res_val = (w_tv & w_pv) ? r_val : '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pnf_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_num_places <= pnf_pkg::CNT_RESET;
            r_num_trans  <= pnf_pkg::CNT_RESET;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pnf_pkg::ST_CLEAR) begin
                r_clr <= r_clr + TW'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pnf_pkg::CFG_NUM_PLACES: r_num_places <= i_cfg_data;
                    pnf_pkg::CFG_NUM_TRANS:  r_num_trans  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= pnf_pkg::t_op'(i_op);
            r_t   <= i_trans_index;
            r_p   <= i_place_index;
            r_w   <= i_weight_value;
            r_sat <= 1'b0;
            r_en  <= 1'b0;
            r_val <= '0;
        end
        if (r_state == pnf_pkg::ST_WAIT_CHK && w_end.act) begin
            r_en  <= w_end.en;
            r_val <= w_end.val;
        end
        if (r_state == pnf_pkg::ST_WAIT_UPD && w_end.act) begin
            r_sat <= w_end.sat;
        end
        if (w_load_out) begin
            r_o_ok  <= w_res_ok;
            r_o_en  <= w_res_en;
            r_o_val <= w_res_val;
            r_o_sat <= w_res_sat;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_ok        = r_o_ok;
    assign o_enabled   = r_o_en;
    assign o_value     = r_o_val;
    assign o_saturated = r_o_sat;

endmodule

// ===== verif/petri_net_firing_engine_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the place/transition net firing engine.
// Predicts every result word from its own copy of markings, arc weights and counts.
// Depends on pnf_pkg and the petri_net_firing_engine RTL.
module petri_net_firing_engine_tb;
    import pnf_pkg::*;

    localparam int NUM_PLACE_SLOTS = 16;
    localparam int NUM_TRANS_SLOTS = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int LONG_HOLD       = 200;
    localparam int PHASE_ITEMS     = 155;

    typedef struct packed {
        logic               ok;
        logic               enabled;
        logic [VALUE_W-1:0] value;
        logic               saturated;
    } t_net_result;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_NUM_PLACES;
    logic [CNT_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op           = OP_RD_MARK;
    logic [IDX_W-1:0]     i_trans_index  = '0;
    logic [IDX_W-1:0]     i_place_index  = '0;
    logic [VALUE_W-1:0]   i_weight_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic                 o_ok;
    logic                 o_enabled;
    logic [VALUE_W-1:0]   o_value;
    logic                 o_saturated;

    logic [VALUE_W-1:0] marking [NUM_PLACE_SLOTS];
    logic [VALUE_W-1:0] arc_in  [NUM_TRANS_SLOTS][NUM_PLACE_SLOTS];
    logic [VALUE_W-1:0] arc_out [NUM_TRANS_SLOTS][NUM_PLACE_SLOTS];
    logic [CNT_W-1:0]   places_in_use = CNT_RESET;
    logic [CNT_W-1:0]   trans_in_use  = CNT_RESET;

    t_net_result pending_results[$];
    t_net_result want;
    int          mismatches;
    int          idle_cycles;
    int          rx_stall;
    int          rx_hold;
    bit          fast_mode;
    int          ops_sent;
    int          fires_sent;
    int          fires_taken;
    int          fires_clipped;
    int          count_settings;

    petri_net_firing_engine DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_trans_index  (i_trans_index),
        .i_place_index  (i_place_index),
        .i_weight_value (i_weight_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_enabled      (o_enabled),
        .o_value        (o_value),
        .o_saturated    (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int place_limit();
        return (places_in_use > NUM_PLACE_SLOTS) ? NUM_PLACE_SLOTS : int'(places_in_use);
    endfunction

    function automatic int trans_limit();
        return (trans_in_use > NUM_TRANS_SLOTS) ? NUM_TRANS_SLOTS : int'(trans_in_use);
    endfunction

    function automatic logic transition_enabled(logic [IDX_W-1:0] t);
        for (int q = 0; q < place_limit(); q++) begin
            if (marking[q] < arc_in[t][q]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_net_result net_apply(t_op op, logic [IDX_W-1:0] t,
                                              logic [IDX_W-1:0] p, logic [VALUE_W-1:0] w);
        t_net_result      r;
        logic             tv;
        logic             pv;
        logic [VALUE_W:0] sum;
        r  = '0;
        tv = t < trans_limit();
        pv = p < place_limit();
        case (op)
            OP_SET_IN: begin
                if (tv && pv) begin
                    arc_in[t][p] = w;
                    r.ok = 1'b1;
                end
            end
            OP_SET_OUT: begin
                if (tv && pv) begin
                    arc_out[t][p] = w;
                    r.ok = 1'b1;
                end
            end
            OP_SET_MARK: begin
                if (pv) begin
                    marking[p] = w;
                    r.ok = 1'b1;
                end
            end
            OP_FIRE: begin
                if (tv && transition_enabled(t)) begin
                    for (int q = 0; q < place_limit(); q++) begin
                        sum = {1'b0, marking[q]} - {1'b0, arc_in[t][q]} + {1'b0, arc_out[t][q]};
                        if (sum[VALUE_W]) begin
                            marking[q]  = '1;
                            r.saturated = 1'b1;
                        end else begin
                            marking[q] = sum[VALUE_W-1:0];
                        end
                    end
                    r.ok      = 1'b1;
                    r.enabled = 1'b1;
                end
            end
            OP_TEST: begin
                if (tv) begin
                    r.ok      = 1'b1;
                    r.enabled = transition_enabled(t);
                end
            end
            OP_RD_MARK: begin
                if (pv) begin
                    r.ok    = 1'b1;
                    r.value = marking[p];
                end
            end
            OP_RD_IN: begin
                if (tv && pv) begin
                    r.ok    = 1'b1;
                    r.value = arc_in[t][p];
                end
            end
            default: begin
                if (tv && pv) begin
                    r.ok    = 1'b1;
                    r.value = arc_out[t][p];
                end
            end
        endcase
        return r;
    endfunction

    function automatic int draw_gap();
        return fast_mode ? 0 : $urandom_range(0, 15);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) rx_stall = draw_gap();
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                i_out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no operation pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_ok);
                    mismatches++;
                end
                if (o_enabled !== want.enabled) begin
                    $error("enabled: expected %0d, got %0d", want.enabled, o_enabled);
                    mismatches++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, o_value);
                    mismatches++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d", want.saturated, o_saturated);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(t_op op, logic [IDX_W-1:0] t, logic [IDX_W-1:0] p,
                           logic [VALUE_W-1:0] w);
        int          gap;
        t_net_result r;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_trans_index  <= t;
        i_place_index  <= p;
        i_weight_value <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = net_apply(op, t, p, w);
        pending_results.push_back(r);
        ops_sent++;
        if (op == OP_FIRE) begin
            fires_sent++;
            fires_taken   += r.enabled;
            fires_clipped += r.saturated;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_counts(logic [CNT_W-1:0] np, logic [CNT_W-1:0] nt);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_NUM_PLACES;
        i_cfg_data  <= np;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        places_in_use = np;
        i_cfg_index <= CFG_NUM_TRANS;
        i_cfg_data  <= nt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        trans_in_use = nt;
        i_cfg_valid <= 1'b0;
        count_settings++;
    endtask

    task automatic test_after_reset();
        send_op(OP_RD_MARK, 4'd0, 4'd15, 16'hFFFF);
        send_op(OP_RD_IN, 4'd15, 4'd15, 16'd0);
        send_op(OP_RD_OUT, 4'd0, 4'd0, 16'd0);
        send_op(OP_TEST, 4'd0, 4'd0, 16'd0);
        send_op(OP_FIRE, 4'd15, 4'd15, 16'd0);
    endtask

    task automatic test_firing();
        send_op(OP_SET_IN, 4'd1, 4'd0, 16'd2);
        send_op(OP_SET_OUT, 4'd1, 4'd1, 16'hFFFF);
        send_op(OP_SET_MARK, 4'd0, 4'd0, 16'd3);
        send_op(OP_FIRE, 4'd1, 4'd0, 16'd0);
        send_op(OP_FIRE, 4'd1, 4'd0, 16'd0);
        send_op(OP_SET_MARK, 4'd0, 4'd0, 16'hFFFF);
        send_op(OP_FIRE, 4'd1, 4'd0, 16'd0);
        send_op(OP_RD_MARK, 4'd0, 4'd1, 16'd0);
        send_op(OP_TEST, 4'd1, 4'd0, 16'd0);
        send_op(OP_RD_IN, 4'd1, 4'd0, 16'd0);
        send_op(OP_RD_OUT, 4'd1, 4'd1, 16'd0);
    endtask

    task automatic test_index_range();
        set_counts(5'd3, 5'd2);
        send_op(OP_SET_IN, 4'd2, 4'd0, 16'h5A5A);
        send_op(OP_SET_MARK, 4'd0, 4'd3, 16'hA5A5);
        send_op(OP_FIRE, 4'd1, 4'd0, 16'd0);
        send_op(OP_FIRE, 4'd2, 4'd0, 16'd0);
        send_op(OP_TEST, 4'd15, 4'd0, 16'd0);
        send_op(OP_RD_OUT, 4'd1, 4'd15, 16'd0);
        set_counts(5'd0, 5'd0);
        send_op(OP_TEST, 4'd0, 4'd0, 16'd0);
        send_op(OP_SET_MARK, 4'd0, 4'd0, 16'd1);
        set_counts(5'd31, 5'd31);
        send_op(OP_RD_MARK, 4'd15, 4'd1, 16'd0);
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold = LONG_HOLD;
        fast_mode = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_op((i % 2) ? OP_FIRE : OP_RD_MARK, 4'(i), 4'(i), 16'd0);
        end
        fast_mode = 1'b0;
        wait_drained();
    endtask

    function automatic logic [IDX_W-1:0] pick_index(int lim);
        if (lim > 0 && $urandom_range(0, 99) < 85) return IDX_W'($urandom_range(0, lim - 1));
        return IDX_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(t_op op);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return VALUE_W'($urandom());
        if (roll < 15) return 16'hFFFF - VALUE_W'($urandom_range(0, 3));
        if (roll < 18) return '0;
        if (op == OP_SET_MARK) return VALUE_W'($urandom_range(0, 200));
        return VALUE_W'($urandom_range(0, 3));
    endfunction

    task automatic run_random_ops(int n);
        t_op op;
        int  roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15)      op = OP_SET_IN;
            else if (roll < 25) op = OP_SET_OUT;
            else if (roll < 40) op = OP_SET_MARK;
            else if (roll < 65) op = OP_FIRE;
            else if (roll < 75) op = OP_TEST;
            else if (roll < 85) op = OP_RD_MARK;
            else if (roll < 93) op = OP_RD_IN;
            else                op = OP_RD_OUT;
            send_op(op, pick_index(trans_limit()), pick_index(place_limit()), pick_value(op));
        end
    endtask

    task automatic test_random_phases();
        logic [CNT_W-1:0] np_list [10] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0,
                                           5'd7, 5'd17, 5'd2, 5'd16, 5'd9};
        logic [CNT_W-1:0] nt_list [10] = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd6,
                                           5'd0, 5'd2, 5'd17, 5'd16, 5'd12};
        for (int ph = 0; ph < 10; ph++) begin
            set_counts(np_list[ph], nt_list[ph]);
            fast_mode = (ph % 3 == 2);
            run_random_ops(PHASE_ITEMS);
        end
        fast_mode = 1'b0;
    endtask

    initial begin
        foreach (marking[q]) marking[q] = '0;
        foreach (arc_in[t, q]) begin
            arc_in[t][q]  = '0;
            arc_out[t][q] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_firing();
        test_index_range();
        test_backpressure();
        test_random_phases();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d operations over %0d count settings, zero and oversize counts included.",
                 ops_sent, count_settings);
        $display("Fires: %0d issued, %0d enabled, %0d clipped at the token maximum.",
                 fires_sent, fires_taken, fires_clipped);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pnf_pkg.sv
hdl/pnf_ram.sv
hdl/pnf_cell.sv
hdl/petri_net_firing_engine.sv
verif/petri_net_firing_engine_tb.sv
